>>> hw/rtl/edge_counter_timer_core_defines.svh
// ----------------------------------------------------------------------------
// Edge counter timer assertion macros
// Shorthand for clocked assertions; expects clk_i and rst_ni in scope.
// ----------------------------------------------------------------------------
`ifndef EDGE_COUNTER_TIMER_CORE_DEFINES_SVH
`define EDGE_COUNTER_TIMER_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define ECT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define ECT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/ect_pkg.sv
// ----------------------------------------------------------------------------
// Edge counter timer package
// Shared widths, register indexes, codes and the configuration struct.
// ----------------------------------------------------------------------------
package ect_pkg;

  localparam int MaxLanes = 4;
  localparam int SampleW  = 16;
  localparam int CountW   = 31;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 31;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegEdgeSelect   = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOutputMode   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCountLimit   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegHighThreshold = 3'd3;
  localparam logic [CfgIdxW-1:0] RegLowThreshold = 3'd4;

  // edge select codes
  localparam logic [1:0] EdgeRise = 2'd0;
  localparam logic [1:0] EdgeFall = 2'd1;
  localparam logic [1:0] EdgeBoth = 2'd2;
  // spare code, behaves like both edges
  localparam logic [1:0] EdgeSpare = 2'd3;

  // output mode codes
  localparam logic ModeCount = 1'b0;
  localparam logic ModePulse = 1'b1;

  // reset values
  localparam logic [CountW-1:0]         LimitReset  = 31'd100;
  localparam logic signed [SampleW-1:0] HighThrReset = 16'sd1966;
  localparam logic signed [SampleW-1:0] LowThrReset  = 16'sd655;

  typedef struct packed {
    logic [1:0]                edge_select;
    logic                      output_mode;
    logic [CountW-1:0]         count_limit;
    logic signed [SampleW-1:0] high_thr;
    logic signed [SampleW-1:0] low_thr;
  } cfg_t;

endpackage

>>> hw/rtl/ect_lane.sv
// ----------------------------------------------------------------------------
// Edge counter timer lane
// Hysteresis squaring, edge detect and modulo up-count for one lane.
// ----------------------------------------------------------------------------
module ect_lane (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              step_i,
  input  logic                              clear_i,
  input  ect_pkg::cfg_t                     cfg_i,
  input  logic signed [ect_pkg::SampleW-1:0] sample_i,
  output logic [ect_pkg::CountW-1:0]        value_o
);

  logic                          level_q, level_d;
  logic [ect_pkg::CountW-1:0]    count_q, count_d;
  logic [ect_pkg::CountW:0]      inc;
  logic                          toggled;
  logic                          act;
  logic                          wrap;

  always_comb begin
    if (sample_i >= cfg_i.high_thr) begin
      level_d = 1'b1;
    end else if (sample_i <= cfg_i.low_thr) begin
      level_d = 1'b0;
    end else begin
      level_d = level_q;
    end
  end

  // previous level always equals the stored level between items
  assign toggled = level_d != level_q;

  always_comb begin
    unique case (cfg_i.edge_select)
      ect_pkg::EdgeRise: act = toggled & level_d;
      ect_pkg::EdgeFall: act = toggled & ~level_d;
      default:           act = toggled;
    endcase
  end

  assign inc  = {1'b0, count_q} + (ect_pkg::CountW + 1)'(1);
  assign wrap = inc >= {1'b0, cfg_i.count_limit};

  always_comb begin
    count_d = count_q;
    if (act) begin
      count_d = wrap ? '0 : inc[ect_pkg::CountW-1:0];
    end
  end

  assign value_o = (cfg_i.output_mode == ect_pkg::ModeCount) ? count_d
                 : {{(ect_pkg::CountW-1){1'b0}}, act & wrap};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 1'b0;
      count_q <= '0;
    end else if (clear_i) begin
      level_q <= 1'b0;
      count_q <= '0;
    end else if (step_i) begin
      level_q <= level_d;
      count_q <= count_d;
    end
  end

endmodule

>>> hw/rtl/ect_merge.sv
// ----------------------------------------------------------------------------
// Edge counter timer merge stage
// Gathers the lane results into one item with an output register and skid.
// ----------------------------------------------------------------------------
module ect_merge (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [ect_pkg::CountW-1:0] lane_value_i [ect_pkg::MaxLanes],
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [ect_pkg::CountW-1:0] value_o [ect_pkg::MaxLanes]
);

  logic                       out_valid_q;
  logic                       skid_valid_q;
  logic [ect_pkg::CountW-1:0] out_data_q  [ect_pkg::MaxLanes];
  logic [ect_pkg::CountW-1:0] skid_data_q [ect_pkg::MaxLanes];
  logic                       in_fire;
  logic                       out_fire;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i & ~skid_valid_q;
  assign out_fire   = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_data_q <= skid_data_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_data_q <= lane_value_i;
      end else begin
        out_data_q <= lane_value_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = out_data_q;

endmodule

>>> hw/rtl/edge_counter_timer_core.sv
// ----------------------------------------------------------------------------
// Edge counter timer core
// Up to four lanes of hysteresis edge counting with modulo wrap or pulse.
// ----------------------------------------------------------------------------
// usage:
//   input channel (in_valid_i / in_stall_o) carries one sample per lane each
//   item; output channel (out_valid_o / out_stall_i) returns one value per
//   lane for every item, in order.
//   all lanes run side by side; each compares, detects the edge and bumps its
//   count in the accept cycle, so one item is taken every cycle while
//   in_stall_o is low. the result is registered: it enters the output
//   register, or the skid register while a stalled result holds it.
//   a stalled result is held; one more item lands in a skid register, after
//   which in_stall_o rises until the receiver drains the output.
//   reset loads the default registers and clears levels and counts. any
//   write to a listed register also clears levels and counts of all lanes;
//   write only while no item is in flight. writes to other indexes are void.
//   lanes at or above LANES output 0.
// ----------------------------------------------------------------------------
`include "edge_counter_timer_core_defines.svh"

module edge_counter_timer_core #(
  parameter int LANES = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [ect_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ect_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic signed [ect_pkg::SampleW-1:0] sample_0_i,
  input  logic signed [ect_pkg::SampleW-1:0] sample_1_i,
  input  logic signed [ect_pkg::SampleW-1:0] sample_2_i,
  input  logic signed [ect_pkg::SampleW-1:0] sample_3_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [ect_pkg::CountW-1:0]         value_0_o,
  output logic [ect_pkg::CountW-1:0]         value_1_o,
  output logic [ect_pkg::CountW-1:0]         value_2_o,
  output logic [ect_pkg::CountW-1:0]         value_3_o
);

  ect_pkg::cfg_t              cfg_q;
  logic                       cfg_hit;
  logic                       lane_clear;
  logic                       in_fire;
  logic signed [ect_pkg::SampleW-1:0] sample [ect_pkg::MaxLanes];
  logic [ect_pkg::CountW-1:0] lane_value [ect_pkg::MaxLanes];
  logic [ect_pkg::CountW-1:0] merged     [ect_pkg::MaxLanes];

  always_comb begin
    unique case (cfg_index_i)
      ect_pkg::RegEdgeSelect,
      ect_pkg::RegOutputMode,
      ect_pkg::RegCountLimit,
      ect_pkg::RegHighThreshold,
      ect_pkg::RegLowThreshold: cfg_hit = 1'b1;
      default:                  cfg_hit = 1'b0;
    endcase
  end

  assign lane_clear = cfg_we_i & cfg_hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.edge_select <= ect_pkg::EdgeRise;
      cfg_q.output_mode <= ect_pkg::ModeCount;
      cfg_q.count_limit <= ect_pkg::LimitReset;
      cfg_q.high_thr    <= ect_pkg::HighThrReset;
      cfg_q.low_thr     <= ect_pkg::LowThrReset;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ect_pkg::RegEdgeSelect:    cfg_q.edge_select <= cfg_data_i[1:0];
        ect_pkg::RegOutputMode:    cfg_q.output_mode <= cfg_data_i[0];
        ect_pkg::RegCountLimit:    cfg_q.count_limit <= cfg_data_i;
        ect_pkg::RegHighThreshold: cfg_q.high_thr    <= cfg_data_i[ect_pkg::SampleW-1:0];
        ect_pkg::RegLowThreshold:  cfg_q.low_thr     <= cfg_data_i[ect_pkg::SampleW-1:0];
        default: ;
      endcase
    end
  end

  assign in_fire = in_valid_i & ~in_stall_o;

  assign sample[0] = sample_0_i;
  assign sample[1] = sample_1_i;
  assign sample[2] = sample_2_i;
  assign sample[3] = sample_3_i;

  for (genvar g = 0; g < ect_pkg::MaxLanes; g++) begin : g_lane
    if (g < LANES) begin : g_used
      ect_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .step_i   (in_fire),
        .clear_i  (lane_clear),
        .cfg_i    (cfg_q),
        .sample_i (sample[g]),
        .value_o  (lane_value[g])
      );
    end else begin : g_unused
      assign lane_value[g] = '0;
    end
  end

  ect_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .lane_value_i (lane_value),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .value_o      (merged)
  );

  assign value_0_o = merged[0];
  assign value_1_o = merged[1];
  assign value_2_o = merged[2];
  assign value_3_o = merged[3];

  // skid only fills behind a full output register
  `ECT_ASSERT_NOW(a_skid_behind_out, in_stall_o, out_valid_o,
    "skid full while output register empty")

  // an item accepted while the output register is empty shows up at the output
  `ECT_ASSERT_NEXT(a_item_lands, in_fire && !out_valid_o, out_valid_o,
    "accepted item did not reach the output register")

  // an item taken behind a stalled result fills the skid
  `ECT_ASSERT_NEXT(a_skid_fills, in_fire && out_valid_o && out_stall_i, in_stall_o,
    "item behind stalled result not held in skid")

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// Edge counter timer core testbench
// Drives ticks of four signed samples through edge_counter_timer_core under a
// series of register settings and idle patterns. A scoreboard keeps its own
// copy of the lane levels and counts, predicts every result and compares the
// values in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int Lanes      = 4;
  localparam int Phases     = 12;
  localparam int PhaseItems = 150;
  localparam int HoldCycles = 300;
  localparam int QuietLimit = 2000;

  typedef logic [ect_pkg::MaxLanes-1:0][ect_pkg::SampleW-1:0] tick_t;
  typedef logic [ect_pkg::MaxLanes-1:0][ect_pkg::CountW-1:0]  value_set_t;

  class edge_count_scoreboard;
    logic [1:0]                         edge_sel;
    logic                               out_mode;
    logic [ect_pkg::CountW-1:0]         limit;
    logic signed [ect_pkg::SampleW-1:0] high_thr;
    logic signed [ect_pkg::SampleW-1:0] low_thr;
    bit                                 level[ect_pkg::MaxLanes];
    bit                                 prev_level[ect_pkg::MaxLanes];
    logic [ect_pkg::CountW-1:0]         count[ect_pkg::MaxLanes];
    value_set_t                         expected_values[$];
    int                                 errors;
    int                                 ticks;
    int                                 results;

    function new();
      edge_sel = ect_pkg::EdgeRise;
      out_mode = ect_pkg::ModeCount;
      limit    = ect_pkg::LimitReset;
      high_thr = ect_pkg::HighThrReset;
      low_thr  = ect_pkg::LowThrReset;
      clear_lanes();
    endfunction

    function void clear_lanes();
      for (int i = 0; i < ect_pkg::MaxLanes; i++) begin
        level[i]      = 1'b0;
        prev_level[i] = 1'b0;
        count[i]      = '0;
      end
    endfunction

    function void write_reg(logic [ect_pkg::CfgIdxW-1:0] idx,
                            logic [ect_pkg::CfgDataW-1:0] data);
      case (idx)
        ect_pkg::RegEdgeSelect:    edge_sel = data[1:0];
        ect_pkg::RegOutputMode:    out_mode = data[0];
        ect_pkg::RegCountLimit:    limit    = data[ect_pkg::CountW-1:0];
        ect_pkg::RegHighThreshold: high_thr = data[ect_pkg::SampleW-1:0];
        ect_pkg::RegLowThreshold:  low_thr  = data[ect_pkg::SampleW-1:0];
        default:                   return;
      endcase
      clear_lanes();
    endfunction

    function int pending();
      return expected_values.size();
    endfunction

    function void note_tick(tick_t s);
      value_set_t                 v;
      logic [ect_pkg::CountW:0]   nxt;
      bit                         act;
      bit                         wrap;
      v = '0;
      for (int i = 0; i < Lanes; i++) begin
        act  = 1'b0;
        wrap = 1'b0;
        // high test wins when the thresholds overlap
        if ($signed(s[i]) >= high_thr) begin
          level[i] = 1'b1;
        end else if ($signed(s[i]) <= low_thr) begin
          level[i] = 1'b0;
        end
        if (level[i] != prev_level[i]) begin
          case (edge_sel)
            ect_pkg::EdgeRise: act = level[i];
            ect_pkg::EdgeFall: act = !level[i];
            default:           act = 1'b1;
          endcase
        end
        if (act) begin
          nxt = {1'b0, count[i]} + 1'b1;
          // a zero limit wraps on every counted edge
          if (nxt >= {1'b0, limit}) begin
            nxt  = '0;
            wrap = 1'b1;
          end
          count[i] = nxt[ect_pkg::CountW-1:0];
        end
        v[i] = (out_mode == ect_pkg::ModeCount) ? count[i]
             : {{(ect_pkg::CountW-1){1'b0}}, wrap};
        prev_level[i] = level[i];
      end
      expected_values.push_back(v);
      ticks++;
    endfunction

    function void check_values(value_set_t got);
      value_set_t want;
      results++;
      if (expected_values.size() == 0) begin
        $error("result with no item outstanding: %h", got);
        errors++;
        return;
      end
      want = expected_values.pop_front();
      for (int i = 0; i < ect_pkg::MaxLanes; i++) begin
        if (got[i] !== want[i]) begin
          $error("value_%0d mismatch: expected %0d, actual %0d", i, want[i], got[i]);
          errors++;
        end
      end
    endfunction
  endclass

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [ect_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [ect_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [ect_pkg::SampleW-1:0]  sample_0_i = '0;
  logic [ect_pkg::SampleW-1:0]  sample_1_i = '0;
  logic [ect_pkg::SampleW-1:0]  sample_2_i = '0;
  logic [ect_pkg::SampleW-1:0]  sample_3_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [ect_pkg::CountW-1:0]   value_0_o;
  logic [ect_pkg::CountW-1:0]   value_1_o;
  logic [ect_pkg::CountW-1:0]   value_2_o;
  logic [ect_pkg::CountW-1:0]   value_3_o;

  edge_count_scoreboard sb;
  int tx_idle_pct = 9;
  int rx_stall_pct = 46;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  edge_counter_timer_core #(
    .LANES(Lanes)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sample_0_i (sample_0_i),
    .sample_1_i (sample_1_i),
    .sample_2_i (sample_2_i),
    .sample_3_i (sample_3_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .value_0_o  (value_0_o),
    .value_1_o  (value_1_o),
    .value_2_o  (value_2_o),
    .value_3_o  (value_3_o)
  );

  always #5 clk_i = ~clk_i;

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HoldCycles;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < rx_stall_pct);
    end
  end

  // both channels observed at the edge, before any update lands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_tick({sample_3_i, sample_2_i, sample_1_i, sample_0_i});
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_values({value_3_o, value_2_o, value_1_o, value_0_o});
      end
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QuietLimit) begin
        $display("no handshake for %0d cycles", QuietLimit);
        $display("edge_counter_timer_core verification failed");
        $finish;
      end
    end
  end

  task automatic send_item(input tick_t s);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_0_i <= s[0];
    sample_1_i <= s[1];
    sample_2_i <= s[2];
    sample_3_i <= s[3];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // stop offering and wait until every outstanding result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [ect_pkg::CfgIdxW-1:0] idx,
                           input logic [ect_pkg::CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic set_all_regs(input int edge_sel,
                              input int mode,
                              input int limit,
                              input int high_thr,
                              input int low_thr);
    cfg_write(ect_pkg::RegEdgeSelect, ect_pkg::CfgDataW'(edge_sel));
    cfg_write(ect_pkg::RegOutputMode, ect_pkg::CfgDataW'(mode));
    cfg_write(ect_pkg::RegCountLimit, ect_pkg::CfgDataW'(limit));
    cfg_write(ect_pkg::RegHighThreshold, ect_pkg::CfgDataW'(high_thr));
    cfg_write(ect_pkg::RegLowThreshold, ect_pkg::CfgDataW'(low_thr));
  endtask

  initial begin
    tick_t t;
    int    v;
    int    dir_samples[16];
    int    lim;
    sb = new();
    dir_samples = '{0, 32767, -32768, 1966, 1965, 1000, 655, 656,
                    1966, 1000, 654, 2000, 655, -1, 32767, -32768};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: threshold edges, extremes, hysteresis band
    for (int k = 0; k < 16; k++) begin
      for (int i = 0; i < ect_pkg::MaxLanes; i++) begin
        t[i] = dir_samples[(k + i) % 16][ect_pkg::SampleW-1:0];
      end
      send_item(t);
    end

    for (int p = 0; p < Phases; p++) begin
      drain();
      tx_idle_pct = (p < 4) ? 9 : (p < 8) ? 46 : 0;
      rx_stall_pct <= (p < 4) ? 46 : (p < 8) ? 9 : 0;
      case (p)
        0: set_all_regs(int'(ect_pkg::EdgeRise), int'(ect_pkg::ModeCount), 3, 1966, 655);
        1: set_all_regs(int'(ect_pkg::EdgeFall), int'(ect_pkg::ModeCount), 1, 100, -100);
        2: set_all_regs(int'(ect_pkg::EdgeBoth), int'(ect_pkg::ModePulse), 2, 0, -1);
        3: set_all_regs(int'(ect_pkg::EdgeSpare), int'(ect_pkg::ModePulse), 0, 4096, -4096);
        4: set_all_regs(int'(ect_pkg::EdgeBoth), int'(ect_pkg::ModeCount), 32'h7FFF_FFFF,
                        32767, -32768);
        5: set_all_regs(int'(ect_pkg::EdgeRise), int'(ect_pkg::ModeCount), 5, 0, 1000);
        6: set_all_regs(int'(ect_pkg::EdgeBoth), int'(ect_pkg::ModeCount), 7, 1966, 655);
        7: begin
          // unused indexes: levels and counts must survive
          for (int r = ect_pkg::RegLowThreshold + 1; r < 2 ** ect_pkg::CfgIdxW; r++) begin
            cfg_write(r[ect_pkg::CfgIdxW-1:0], ect_pkg::CfgDataW'($urandom));
          end
        end
        8: set_all_regs(int'(ect_pkg::EdgeRise), int'(ect_pkg::ModePulse), 4, -32768, 32767);
        default: begin
          lim = ($urandom_range(0, 3) == 0) ? int'($urandom) : int'($urandom_range(0, 6));
          set_all_regs(int'($urandom), int'($urandom), lim, int'($urandom), int'($urandom));
        end
      endcase
      cfg_we_i <= 1'b0;
      // long receiver hold-off while the sender keeps pushing
      if (p == 9) hold_requests <= hold_requests + 1;
      for (int k = 0; k < PhaseItems; k++) begin
        for (int i = 0; i < ect_pkg::MaxLanes; i++) begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3: v = int'(sb.high_thr) + int'($urandom_range(0, 40));
            4, 5, 6, 7: v = int'(sb.low_thr) - int'($urandom_range(0, 40));
            8:          v = int'($urandom_range(0, 65535)) - 32768;
            default:    v = $urandom_range(0, 1) ? 32767 : -32768;
          endcase
          if (v > 32767) v = 32767;
          if (v < -32768) v = -32768;
          t[i] = v[ect_pkg::SampleW-1:0];
        end
        send_item(t);
      end
    end

    drain();
    $display("%0d ticks sent, %0d results checked over %0d register phases",
             sb.ticks, sb.results, Phases);
    $display("rise, fall, both and spare edge codes; count and pulse output; limits 0 to max");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("edge_counter_timer_core verification clean");
    end else begin
      $display("edge_counter_timer_core verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ect_pkg.sv
hw/rtl/ect_lane.sv
hw/rtl/ect_merge.sv
hw/rtl/edge_counter_timer_core.sv
test/tb.sv
